// ===== sv/csp_pkg.sv =====
package csp_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned POWER_W = 7;
	localparam int unsigned FREQ_W  = 17;
	localparam int unsigned MILLI_W = 18;
	localparam int unsigned FIELD_W = 3;
	localparam int unsigned ACC_W   = 8;
	localparam int unsigned FRAC_W  = 10;
	localparam int unsigned CNT_W   = 2;

	localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
	localparam logic [BYTE_W-1:0] CH_POINT = 8'h2E;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

	localparam logic [FIELD_W-1:0] FLD_POWER = 3'd3;
	localparam logic [FIELD_W-1:0] FLD_FREQ  = 3'd4;
	localparam logic [FIELD_W-1:0] FLD_TAIL  = 3'd5;

	localparam logic [ACC_W-1:0]   POWER_MAX      = 8'd100;
	localparam logic [ACC_W-1:0]   ACC_MAX        = 8'd255;
	localparam logic [MILLI_W-1:0] FREQ_MIN_MILLI = 18'd1;
	localparam logic [MILLI_W-1:0] FREQ_MAX_MILLI = 18'd100000;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_BAD = 1'b1;

	typedef struct packed {
		logic [FREQ_W-1:0]  freq_milli;
		logic [POWER_W-1:0] power;
		logic               polarity;
		logic               mode;
		logic               enable;
		logic               status;
	} result_t;

endpackage

// ===== sv/coil_setting_command_parser_top.sv =====
// Channel  | Direction | Payload
// s_axis   | in        | tdata[7:0] rx_byte
// m_axis   | out       | tdata[27:0] status, enable, mode, polarity, power, freq_milli
//
// A byte is registered on acceptance and parsed from that register; a newline can be held there.
// A newline yields one result transaction, passing through the byte register and the output register.
// One byte can be accepted in every cycle while the output register is free.
// A newline waiting behind a full, stalled output register holds the input.
// Reset clears all line state and the applied settings to zero.
module coil_setting_command_parser_top import csp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // [0] status, [1] enable_out, [2] mode_out,
	                                   // [3] polarity_out, [10:4] power_out,
	                                   // [27:11] freq_milli_out, [31:28] zero
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              advance;
	logic              step;
	logic              res_valid;
	result_t           res;
	logic              out_valid_q;
	result_t           out_q;

	assign advance       = !(byte_s1 == CH_NL) || !out_valid_q || m_axis_tready;
	assign step          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	csp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.rx_byte   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, out_q};

endmodule

// ===== sv/csp_parser.sv =====
module csp_parser import csp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [BYTE_W-1:0] rx_byte,
	output logic              res_valid,
	output result_t           res
);

	logic [FIELD_W-1:0] field_q, field_d;
	logic [ACC_W-1:0]   acc_q, acc_d;
	logic [FRAC_W-1:0]  frac_q, frac_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic               bad_q, bad_d;
	logic               start_q, start_d;
	logic               wspend_q, wspend_d;
	logic               point_q, point_d;
	logic               sticky_q, sticky_d;
	logic [2:0]         pend_bits_q, pend_bits_d;
	logic [POWER_W-1:0] pend_power_q, pend_power_d;
	logic [2:0]         app_bits_q, app_bits_d;
	logic [POWER_W-1:0] app_power_q, app_power_d;
	logic [FREQ_W-1:0]  app_freq_q, app_freq_d;

	logic [MILLI_W-1:0] frac_milli;
	logic [MILLI_W-1:0] freq_milli;
	logic               freq_ok;
	logic               is_ws;
	logic               is_digit;
	logic [3:0]         digit;
	logic [11:0]        acc_ext;
	logic [FRAC_W-1:0]  frac_ext;
	logic               ok;

	always_comb begin
		case (cnt_q)
			2'd1: frac_milli = MILLI_W'(frac_q) * MILLI_W'(100);
			2'd2: frac_milli = MILLI_W'(frac_q) * MILLI_W'(10);
			2'd3: frac_milli = MILLI_W'(frac_q);
			default: frac_milli = '0;
		endcase
		freq_milli = MILLI_W'(acc_q) * MILLI_W'(1000) + frac_milli;
		freq_ok = (freq_milli >= FREQ_MIN_MILLI) && (freq_milli <= FREQ_MAX_MILLI)
			&& !((freq_milli == FREQ_MAX_MILLI) && sticky_q);
	end

	assign is_ws    = (rx_byte == CH_SPACE) || (rx_byte inside {[CH_TAB:CH_CR]});
	assign is_digit = rx_byte inside {[CH_ZERO:CH_NINE]};
	assign digit    = 4'(rx_byte - CH_ZERO);
	assign acc_ext  = 12'(acc_q) * 12'd10 + 12'(digit);
	assign frac_ext = 10'(frac_q * 10'd10 + 10'(digit));

	always_comb begin
		field_d      = field_q;
		acc_d        = acc_q;
		frac_d       = frac_q;
		cnt_d        = cnt_q;
		bad_d        = bad_q;
		start_d      = start_q;
		wspend_d     = wspend_q;
		point_d      = point_q;
		sticky_d     = sticky_q;
		pend_bits_d  = pend_bits_q;
		pend_power_d = pend_power_q;
		app_bits_d   = app_bits_q;
		app_power_d  = app_power_q;
		app_freq_d   = app_freq_q;
		res_valid    = 1'b0;
		ok           = 1'b0;

		if (step) begin
			if (rx_byte == CH_NL) begin
				ok = start_q && !bad_q;
				if (field_q == FLD_FREQ) begin
					ok = ok && freq_ok;
				end else if (field_q != FLD_TAIL) begin
					ok = 1'b0;
				end
				if (ok) begin
					app_bits_d  = pend_bits_q;
					app_power_d = pend_power_q;
					app_freq_d  = FREQ_W'(freq_milli);
				end
				res_valid    = 1'b1;
				field_d      = '0;
				acc_d        = '0;
				frac_d       = '0;
				cnt_d        = '0;
				bad_d        = 1'b0;
				start_d      = 1'b0;
				wspend_d     = 1'b0;
				point_d      = 1'b0;
				sticky_d     = 1'b0;
				pend_bits_d  = '0;
				pend_power_d = '0;
			end else if (is_ws) begin
				if (start_q) begin
					wspend_d = 1'b1;
				end
			end else begin
				start_d = 1'b1;
				if (wspend_q) begin
					wspend_d = 1'b0;
					if (field_q != FLD_TAIL) begin
						bad_d = 1'b1;
					end
				end
				if (!bad_d) begin
					if (field_q == FLD_TAIL) begin
						if (rx_byte == CH_SEMI) begin
							bad_d = 1'b1;
						end
					end else if (rx_byte == CH_SEMI) begin
						if (field_q < FLD_POWER) begin
							if (acc_q > 8'd1) begin
								bad_d = 1'b1;
							end else begin
								pend_bits_d[field_q[1:0]] = acc_q[0];
							end
						end else if (field_q == FLD_POWER) begin
							if (acc_q > POWER_MAX) begin
								bad_d = 1'b1;
							end else begin
								pend_power_d = POWER_W'(acc_q);
							end
						end else if (!freq_ok) begin
							bad_d = 1'b1;
						end
						if (field_q < FLD_FREQ) begin
							acc_d   = '0;
							field_d = field_q + 3'd1;
						end else begin
							field_d = FLD_TAIL;
						end
					end else if (is_digit) begin
						if (field_q < FLD_FREQ || !point_q) begin
							acc_d = (acc_ext > 12'(ACC_MAX)) ? ACC_MAX : ACC_W'(acc_ext);
						end else if (cnt_q < 2'd3) begin
							frac_d = frac_ext;
							cnt_d  = cnt_q + 2'd1;
						end else if (digit != 4'd0) begin
							sticky_d = 1'b1;
						end
					end else if (rx_byte == CH_POINT && field_q == FLD_FREQ) begin
						if (point_q) begin
							bad_d = 1'b1;
						end else begin
							point_d = 1'b1;
						end
					end else begin
						bad_d = 1'b1;
					end
				end
			end
		end

		res.status     = ok ? STATUS_OK : STATUS_BAD;
		res.enable     = app_bits_d[0];
		res.mode       = app_bits_d[1];
		res.polarity   = app_bits_d[2];
		res.power      = app_power_d;
		res.freq_milli = app_freq_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_q      <= '0;
			acc_q        <= '0;
			frac_q       <= '0;
			cnt_q        <= '0;
			bad_q        <= 1'b0;
			start_q      <= 1'b0;
			wspend_q     <= 1'b0;
			point_q      <= 1'b0;
			sticky_q     <= 1'b0;
			pend_bits_q  <= '0;
			pend_power_q <= '0;
			app_bits_q   <= '0;
			app_power_q  <= '0;
			app_freq_q   <= '0;
		end else begin
			field_q      <= field_d;
			acc_q        <= acc_d;
			frac_q       <= frac_d;
			cnt_q        <= cnt_d;
			bad_q        <= bad_d;
			start_q      <= start_d;
			wspend_q     <= wspend_d;
			point_q      <= point_d;
			sticky_q     <= sticky_d;
			pend_bits_q  <= pend_bits_d;
			pend_power_q <= pend_power_d;
			app_bits_q   <= app_bits_d;
			app_power_q  <= app_power_d;
			app_freq_q   <= app_freq_d;
		end
	end

endmodule
